### rtl/cbcr_pkg.sv
package cbcr_pkg;

	localparam int POS_W      = 24;
	localparam int RAD_W      = 16;
	localparam int SIZE_W     = 23;
	localparam int GAIN_W     = 16;
	localparam int GAIN_SHIFT = 15;
	localparam int DIST_EXT   = 8;
	localparam int CFG_IDX_W  = 1;

	// squared distance, its scaled copy for the root, and the push-out numerator
	localparam int D2_W   = 2 * RAD_W + 1;
	localparam int N_W    = D2_W + 2 * DIST_EXT;
	localparam int ROOT_W = (N_W + 1) / 2;
	localparam int NUM_W  = 2 * RAD_W + DIST_EXT;
	localparam int Q_W    = RAD_W;

	localparam int SQ_STEPS  = ROOT_W;
	localparam int DIV_STEPS = Q_W;

	localparam logic [GAIN_W-1:0] SPEEDUP_RESET  = 16'd34406;
	localparam logic [GAIN_W-1:0] MOMENTUM_RESET = 16'd6554;
	localparam logic [GAIN_W-1:0] GAIN_HALF      = 16'd16384;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPEEDUP  = 1'b0,
		REG_MOMENTUM = 1'b1
	} cfg_reg_t;

	// everything the back end needs besides the root and the quotients
	typedef struct packed {
		logic                    hit;
		logic                    neg_x;
		logic                    neg_y;
		logic signed [POS_W:0]   near_x;
		logic signed [POS_W:0]   near_y;
		logic [POS_W-1:0]        cx;
		logic [POS_W-1:0]        cy;
		logic [POS_W-1:0]        vx;
		logic [POS_W-1:0]        vy;
		logic [POS_W-1:0]        rvx;
		logic [POS_W-1:0]        rvy;
	} cbcr_side_t;

	typedef struct packed {
		logic [NUM_W-1:0] num_x;
		logic [NUM_W-1:0] num_y;
	} cbcr_num_t;

	function automatic logic [POS_W-1:0] sat_pos(input logic signed [POS_W+1:0] v);
		logic signed [POS_W+1:0] hi;
		logic signed [POS_W+1:0] lo;
		hi = (POS_W+2)'(2 ** (POS_W - 1) - 1);
		lo = -(POS_W+2)'(2 ** (POS_W - 1));
		if (v > hi) begin
			return hi[POS_W-1:0];
		end else if (v < lo) begin
			return lo[POS_W-1:0];
		end
		return v[POS_W-1:0];
	endfunction

endpackage

### rtl/cbcr_front.sv
module cbcr_front import cbcr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_valid,
	input  logic [POS_W-1:0]     circle_x,
	input  logic [POS_W-1:0]     circle_y,
	input  logic [POS_W-1:0]     circle_vx,
	input  logic [POS_W-1:0]     circle_vy,
	input  logic [RAD_W-1:0]     circle_radius,
	input  logic [POS_W-1:0]     box_left,
	input  logic [POS_W-1:0]     box_top,
	input  logic [SIZE_W-1:0]    box_width,
	input  logic [SIZE_W-1:0]    box_height,
	input  logic [POS_W-1:0]     box_vx,
	input  logic [POS_W-1:0]     box_vy,
	input  logic [GAIN_W-1:0]    speedup_gain,
	input  logic [GAIN_W-1:0]    momentum_gain,
	output logic                 valid_o,
	output cbcr_side_t           side_o,
	output cbcr_num_t            num_o,
	output logic [N_W-1:0]       n_o
);

	localparam int GP_W = POS_W + GAIN_W;

	// stage 1: clamp, offsets, early reject
	logic signed [POS_W:0]   cx_e, cy_e, lft_e, top_e, rgt, bot, nx, ny;
	logic signed [POS_W+1:0] dx, dy;
	logic [POS_W+1:0]        ax, ay;
	logic                    cand, domx;

	always_comb begin
		cx_e  = $signed({circle_x[POS_W-1], circle_x});
		cy_e  = $signed({circle_y[POS_W-1], circle_y});
		lft_e = $signed({box_left[POS_W-1], box_left});
		top_e = $signed({box_top[POS_W-1], box_top});
		rgt   = lft_e + $signed({2'b00, box_width});
		bot   = top_e + $signed({2'b00, box_height});
		nx = (cx_e > rgt) ? rgt : ((cx_e < lft_e) ? lft_e : cx_e);
		ny = (cy_e > bot) ? bot : ((cy_e < top_e) ? top_e : cy_e);
		dx = $signed({cx_e[POS_W], cx_e}) - $signed({nx[POS_W], nx});
		dy = $signed({cy_e[POS_W], cy_e}) - $signed({ny[POS_W], ny});
		ax = dx[POS_W+1] ? (POS_W+2)'(-dx) : dx;
		ay = dy[POS_W+1] ? (POS_W+2)'(-dy) : dy;
		cand = ((ax != '0) || (ay != '0)) &&
			(ax < (POS_W+2)'(circle_radius)) && (ay < (POS_W+2)'(circle_radius));
		domx = ax > ay;
	end

	function automatic logic [POS_W-1:0] mag(input logic [POS_W-1:0] v);
		return v[POS_W-1] ? (~v + 1'b1) : v;
	endfunction

	logic                 v_s1, cand_s1, negx_s1, negy_s1;
	logic [POS_W-1:0]     cx_s1, cy_s1, vx_s1, vy_s1;
	logic [RAD_W-1:0]     r_s1, ax_s1, ay_s1;
	logic signed [POS_W:0] nx_s1, ny_s1;
	logic [POS_W-1:0]     vmx_s1, vmy_s1, bmx_s1, bmy_s1;
	logic                 svx_s1, svy_s1, sbx_s1, sby_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cand_s1 <= cand;
			negx_s1 <= dx[POS_W+1];
			negy_s1 <= dy[POS_W+1];
			cx_s1   <= circle_x;
			cy_s1   <= circle_y;
			vx_s1   <= circle_vx;
			vy_s1   <= circle_vy;
			r_s1    <= circle_radius;
			ax_s1   <= ax[RAD_W-1:0];
			ay_s1   <= ay[RAD_W-1:0];
			nx_s1   <= nx;
			ny_s1   <= ny;
			vmx_s1  <= mag(circle_vx);
			vmy_s1  <= mag(circle_vy);
			bmx_s1  <= mag(box_vx);
			bmy_s1  <= mag(box_vy);
			// dominant axis flips its component, ties go to y
			svx_s1  <= circle_vx[POS_W-1] ^ domx;
			svy_s1  <= circle_vy[POS_W-1] ^ ~domx;
			sbx_s1  <= box_vx[POS_W-1];
			sby_s1  <= box_vy[POS_W-1];
		end
	end

	// stage 2: squares, radius products, gain products
	function automatic logic [POS_W-1:0] gmul(input logic [POS_W-1:0] m,
		input logic [GAIN_W-1:0] g);
		logic [GP_W:0] t;
		t = (GP_W+1)'(m) * (GP_W+1)'(g) + (GP_W+1)'(GAIN_HALF);
		return t[GAIN_SHIFT +: POS_W];
	endfunction

	logic                 v_s2, cand_s2, negx_s2, negy_s2;
	logic [POS_W-1:0]     cx_s2, cy_s2, vx_s2, vy_s2;
	logic signed [POS_W:0] nx_s2, ny_s2;
	logic [2*RAD_W-1:0]   sqx_s2, sqy_s2, rr_s2, pxr_s2, pyr_s2;
	logic [POS_W-1:0]     gvx_s2, gvy_s2, gbx_s2, gby_s2;
	logic                 svx_s2, svy_s2, sbx_s2, sby_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cand_s2 <= cand_s1;
			negx_s2 <= negx_s1;
			negy_s2 <= negy_s1;
			cx_s2   <= cx_s1;
			cy_s2   <= cy_s1;
			vx_s2   <= vx_s1;
			vy_s2   <= vy_s1;
			nx_s2   <= nx_s1;
			ny_s2   <= ny_s1;
			sqx_s2  <= ax_s1 * ax_s1;
			sqy_s2  <= ay_s1 * ay_s1;
			rr_s2   <= r_s1 * r_s1;
			pxr_s2  <= ax_s1 * r_s1;
			pyr_s2  <= ay_s1 * r_s1;
			gvx_s2  <= gmul(vmx_s1, speedup_gain);
			gvy_s2  <= gmul(vmy_s1, speedup_gain);
			gbx_s2  <= gmul(bmx_s1, momentum_gain);
			gby_s2  <= gmul(bmy_s1, momentum_gain);
			svx_s2  <= svx_s1;
			svy_s2  <= svy_s1;
			sbx_s2  <= sbx_s1;
			sby_s2  <= sby_s1;
		end
	end

	// stage 3: distance compare, velocity sums
	function automatic logic signed [POS_W+1:0] term(input logic [POS_W-1:0] m,
		input logic s);
		logic signed [POS_W+1:0] e;
		e = $signed({2'b00, m});
		return s ? -e : e;
	endfunction

	logic [D2_W-1:0] d2;
	assign d2 = {1'b0, sqx_s2} + {1'b0, sqy_s2};

	logic       v_s3;
	cbcr_side_t side_s3;
	cbcr_num_t  num_s3;
	logic [N_W-1:0] n_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3.hit    <= cand_s2 && (d2 < {1'b0, rr_s2});
			side_s3.neg_x  <= negx_s2;
			side_s3.neg_y  <= negy_s2;
			side_s3.near_x <= nx_s2;
			side_s3.near_y <= ny_s2;
			side_s3.cx     <= cx_s2;
			side_s3.cy     <= cy_s2;
			side_s3.vx     <= vx_s2;
			side_s3.vy     <= vy_s2;
			side_s3.rvx    <= sat_pos(term(gvx_s2, svx_s2) + term(gbx_s2, sbx_s2));
			side_s3.rvy    <= sat_pos(term(gvy_s2, svy_s2) + term(gby_s2, sby_s2));
			num_s3.num_x   <= {pxr_s2, {DIST_EXT{1'b0}}};
			num_s3.num_y   <= {pyr_s2, {DIST_EXT{1'b0}}};
			n_s3           <= {d2, {(2*DIST_EXT){1'b0}}};
		end
	end

	assign valid_o = v_s3;
	assign side_o  = side_s3;
	assign num_o   = num_s3;
	assign n_o     = n_s3;

endmodule

### rtl/cbcr_sqrt.sv
module cbcr_sqrt import cbcr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              valid_i,
	input  cbcr_side_t        side_i,
	input  cbcr_num_t         num_i,
	input  logic [N_W-1:0]    n_i,
	output logic              valid_o,
	output cbcr_side_t        side_o,
	output cbcr_num_t         num_o,
	output logic [ROOT_W-1:0] root_o
);

	localparam int NP_W  = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 1;
	localparam int RIN_W = REM_W + 2;

	logic              v_s    [SQ_STEPS];
	logic [ROOT_W-1:0] root_s [SQ_STEPS];
	logic [REM_W-1:0]  rem_s  [SQ_STEPS];
	logic [NP_W-1:0]   n_s    [SQ_STEPS];
	cbcr_side_t        side_s [SQ_STEPS];
	cbcr_num_t         num_s  [SQ_STEPS];

	// one result bit per stage, two radicand bits brought down each time
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		logic              p_v;
		logic [ROOT_W-1:0] p_root;
		logic [REM_W-1:0]  p_rem;
		logic [NP_W-1:0]   p_n;
		cbcr_side_t        p_side;
		cbcr_num_t         p_num;
		logic [RIN_W-1:0]  rin, trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign p_v    = valid_i;
			assign p_root = '0;
			assign p_rem  = '0;
			assign p_n    = NP_W'(n_i);
			assign p_side = side_i;
			assign p_num  = num_i;
		end else begin : g_next
			assign p_v    = v_s[k-1];
			assign p_root = root_s[k-1];
			assign p_rem  = rem_s[k-1];
			assign p_n    = n_s[k-1];
			assign p_side = side_s[k-1];
			assign p_num  = num_s[k-1];
		end

		always_comb begin
			rin   = {p_rem, p_n[NP_W-1 -: 2]};
			trial = {1'b0, p_root, 2'b01};
			ge    = rin >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv) begin
				v_s[k] <= p_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k]  <= ge ? REM_W'(rin - trial) : REM_W'(rin);
				root_s[k] <= {p_root[ROOT_W-2:0], ge};
				n_s[k]    <= {p_n[NP_W-3:0], 2'b00};
				side_s[k] <= p_side;
				num_s[k]  <= p_num;
			end
		end
	end

	assign valid_o = v_s[SQ_STEPS-1];
	assign side_o  = side_s[SQ_STEPS-1];
	assign num_o   = num_s[SQ_STEPS-1];
	assign root_o  = root_s[SQ_STEPS-1];

endmodule

### rtl/cbcr_div.sv
module cbcr_div import cbcr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              valid_i,
	input  cbcr_side_t        side_i,
	input  cbcr_num_t         num_i,
	input  logic [ROOT_W-1:0] ds_i,
	output logic              valid_o,
	output cbcr_side_t        side_o,
	output logic [Q_W-1:0]    qx_o,
	output logic [Q_W-1:0]    qy_o
);

	localparam int D_W = NUM_W + 1;

	logic              v_s    [DIV_STEPS];
	logic [ROOT_W-1:0] ds_s   [DIV_STEPS];
	cbcr_side_t        side_s [DIV_STEPS];
	logic [ROOT_W-1:0] remx_s [DIV_STEPS];
	logic [ROOT_W-1:0] remy_s [DIV_STEPS];
	logic [Q_W-1:0]    lowx_s [DIV_STEPS];
	logic [Q_W-1:0]    lowy_s [DIV_STEPS];
	logic [Q_W-1:0]    qx_s   [DIV_STEPS];
	logic [Q_W-1:0]    qy_s   [DIV_STEPS];

	// rounding: add half the divisor, then a plain long division
	logic [D_W-1:0] dvx, dvy;
	assign dvx = {1'b0, num_i.num_x} + D_W'(ds_i >> 1);
	assign dvy = {1'b0, num_i.num_y} + D_W'(ds_i >> 1);

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic              p_v;
		logic [ROOT_W-1:0] p_ds, p_rx, p_ry;
		logic [Q_W-1:0]    p_lx, p_ly, p_qx, p_qy;
		cbcr_side_t        p_side;
		logic [ROOT_W:0]   rinx, riny, dse;
		logic              gex, gey;

		if (k == 0) begin : g_first
			assign p_v    = valid_i;
			assign p_ds   = ds_i;
			assign p_side = side_i;
			assign p_rx   = dvx[D_W-1 -: ROOT_W];
			assign p_ry   = dvy[D_W-1 -: ROOT_W];
			assign p_lx   = dvx[Q_W-1:0];
			assign p_ly   = dvy[Q_W-1:0];
			assign p_qx   = '0;
			assign p_qy   = '0;
		end else begin : g_next
			assign p_v    = v_s[k-1];
			assign p_ds   = ds_s[k-1];
			assign p_side = side_s[k-1];
			assign p_rx   = remx_s[k-1];
			assign p_ry   = remy_s[k-1];
			assign p_lx   = lowx_s[k-1];
			assign p_ly   = lowy_s[k-1];
			assign p_qx   = qx_s[k-1];
			assign p_qy   = qy_s[k-1];
		end

		always_comb begin
			dse  = {1'b0, p_ds};
			rinx = {p_rx, p_lx[Q_W-1]};
			riny = {p_ry, p_ly[Q_W-1]};
			gex  = rinx >= dse;
			gey  = riny >= dse;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv) begin
				v_s[k] <= p_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ds_s[k]   <= p_ds;
				side_s[k] <= p_side;
				remx_s[k] <= gex ? ROOT_W'(rinx - dse) : ROOT_W'(rinx);
				remy_s[k] <= gey ? ROOT_W'(riny - dse) : ROOT_W'(riny);
				lowx_s[k] <= {p_lx[Q_W-2:0], 1'b0};
				lowy_s[k] <= {p_ly[Q_W-2:0], 1'b0};
				qx_s[k]   <= {p_qx[Q_W-2:0], gex};
				qy_s[k]   <= {p_qy[Q_W-2:0], gey};
			end
		end
	end

	assign valid_o = v_s[DIV_STEPS-1];
	assign side_o  = side_s[DIV_STEPS-1];
	assign qx_o    = qx_s[DIV_STEPS-1];
	assign qy_o    = qy_s[DIV_STEPS-1];

endmodule

### rtl/circle_box_collision_response.sv
// circle versus axis-aligned box contact resolution
//
// input channel: in_valid / in_stall with one circle and one box per
// transaction; output channel: out_valid / out_stall with the resolved
// center, velocity and the hit flag, one result per input transaction,
// in order. a transaction moves when valid is high and stall is low.
// configuration: cfg_we writes cfg_data into the register cfg_index
// selects (0 speedup gain, 1 momentum gain); write only while idle.
// pipeline: 3 front stages, one stage per root bit of the 25-bit distance,
// one stage per bit of the 16-bit push-out quotients, one output register.
// throughput: one transaction per cycle unless a held result stalls the
// pipe; every stage is one pipeline slot.
// stall: when the output register holds a result and out_stall is high the
// whole pipe freezes and in_stall rises in the same cycle; nothing is
// dropped or repeated. with the output register empty the pipe keeps going.
// reset: clears all valid bits and loads the gains with 1.05 and 0.2.
module circle_box_collision_response import cbcr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [POS_W-1:0]     circle_x,
	input  logic [POS_W-1:0]     circle_y,
	input  logic [POS_W-1:0]     circle_vx,
	input  logic [POS_W-1:0]     circle_vy,
	input  logic [RAD_W-1:0]     circle_radius,
	input  logic [POS_W-1:0]     box_left,
	input  logic [POS_W-1:0]     box_top,
	input  logic [SIZE_W-1:0]    box_width,
	input  logic [SIZE_W-1:0]    box_height,
	input  logic [POS_W-1:0]     box_vx,
	input  logic [POS_W-1:0]     box_vy,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GAIN_W-1:0]    cfg_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [POS_W-1:0]     new_x,
	output logic [POS_W-1:0]     new_y,
	output logic [POS_W-1:0]     new_vx,
	output logic [POS_W-1:0]     new_vy,
	output logic                 hit
);

	// gain registers
	logic [GAIN_W-1:0] speedup_q, momentum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speedup_q  <= SPEEDUP_RESET;
			momentum_q <= MOMENTUM_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_SPEEDUP:  speedup_q  <= cfg_data;
				REG_MOMENTUM: momentum_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipe advances unless a finished result is being held back
	logic adv;
	logic out_valid_q;
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv;

	// front: clamp, squares, gain products, contact test
	logic           fr_valid;
	cbcr_side_t     fr_side;
	cbcr_num_t      fr_num;
	logic [N_W-1:0] fr_n;

	cbcr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.in_valid      (in_valid),
		.circle_x      (circle_x),
		.circle_y      (circle_y),
		.circle_vx     (circle_vx),
		.circle_vy     (circle_vy),
		.circle_radius (circle_radius),
		.box_left      (box_left),
		.box_top       (box_top),
		.box_width     (box_width),
		.box_height    (box_height),
		.box_vx        (box_vx),
		.box_vy        (box_vy),
		.speedup_gain  (speedup_q),
		.momentum_gain (momentum_q),
		.valid_o       (fr_valid),
		.side_o        (fr_side),
		.num_o         (fr_num),
		.n_o           (fr_n)
	);

	// distance with eight extra fraction bits
	logic              sq_valid;
	cbcr_side_t        sq_side;
	cbcr_num_t         sq_num;
	logic [ROOT_W-1:0] sq_root;

	cbcr_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.valid_i (fr_valid),
		.side_i  (fr_side),
		.num_i   (fr_num),
		.n_i     (fr_n),
		.valid_o (sq_valid),
		.side_o  (sq_side),
		.num_o   (sq_num),
		.root_o  (sq_root)
	);

	// push-out offsets, rounded half away from zero on the magnitude
	logic           dv_valid;
	cbcr_side_t     dv_side;
	logic [Q_W-1:0] dv_qx, dv_qy;

	cbcr_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.valid_i (sq_valid),
		.side_i  (sq_side),
		.num_i   (sq_num),
		.ds_i    (sq_root),
		.valid_o (dv_valid),
		.side_o  (dv_side),
		.qx_o    (dv_qx),
		.qy_o    (dv_qy)
	);

	// final position: nearest point plus the signed offset
	logic signed [POS_W+1:0] nxe, nye, offx, offy;
	always_comb begin
		nxe  = $signed({dv_side.near_x[POS_W], dv_side.near_x});
		nye  = $signed({dv_side.near_y[POS_W], dv_side.near_y});
		offx = $signed((POS_W+2)'(dv_qx));
		offy = $signed((POS_W+2)'(dv_qy));
		if (dv_side.neg_x) begin
			offx = -offx;
		end
		if (dv_side.neg_y) begin
			offy = -offy;
		end
	end

	logic [POS_W-1:0] new_x_q, new_y_q, new_vx_q, new_vy_q;
	logic             hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q <= dv_side.hit;
			if (dv_side.hit) begin
				new_x_q  <= sat_pos(nxe + offx);
				new_y_q  <= sat_pos(nye + offy);
				new_vx_q <= dv_side.rvx;
				new_vy_q <= dv_side.rvy;
			end else begin
				// no contact: circle passes through untouched
				new_x_q  <= dv_side.cx;
				new_y_q  <= dv_side.cy;
				new_vx_q <= dv_side.vx;
				new_vy_q <= dv_side.vy;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign new_x     = new_x_q;
	assign new_y     = new_y_q;
	assign new_vx    = new_vx_q;
	assign new_vy    = new_vy_q;
	assign hit       = hit_q;

endmodule

### rtl/cbcr_checker.sv
module cbcr_checker import cbcr_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic [POS_W-1:0] new_x,
	input logic [POS_W-1:0] new_y,
	input logic [POS_W-1:0] new_vx,
	input logic [POS_W-1:0] new_vy,
	input logic             hit
);

	// a held result back-pressures the input side
	a_stall_prop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("held result did not stall the input");

	// with an empty output register the pipe never stalls the input
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(new_x) && $stable(new_y) &&
			$stable(new_vx) && $stable(new_vy) && $stable(hit))
		else $error("stalled result changed");

	// reset empties the output
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

endmodule

bind circle_box_collision_response cbcr_checker u_cbcr_checker (.*);

### tb/sv/circle_box_collision_response_tb.sv
`timescale 1ns / 100ps

module circle_box_collision_response_tb;
	import cbcr_pkg::*;

	// one resolved circle as the block reports it
	typedef struct {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [POS_W-1:0] vx;
		logic [POS_W-1:0] vy;
		logic             hit;
	} contact_t;

	// one query: circle and box
	typedef struct {
		logic [POS_W-1:0]  cx;
		logic [POS_W-1:0]  cy;
		logic [POS_W-1:0]  vx;
		logic [POS_W-1:0]  vy;
		logic [RAD_W-1:0]  r;
		logic [POS_W-1:0]  left;
		logic [POS_W-1:0]  top;
		logic [SIZE_W-1:0] w;
		logic [SIZE_W-1:0] h;
		logic [POS_W-1:0]  bvx;
		logic [POS_W-1:0]  bvy;
	} query_t;

	localparam int PIPE_LAT  = 45;
	localparam int WD_LIMIT  = 20000;
	localparam int N_RANDOM  = 500;

	int errors = 0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic longint sat24(input longint v);
		if (v > 64'sd8388607) return 64'sd8388607;
		if (v < -64'sd8388608) return -64'sd8388608;
		return v;
	endfunction

	function automatic longint apply_gain(input longint v, input logic [GAIN_W-1:0] g);
		longint unsigned mag;
		longint unsigned q;
		mag = (v < 0) ? -v : v;
		q = (mag * g + 16384) >> GAIN_SHIFT;
		return (v < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint round_div(input longint num, input longint unsigned den);
		longint unsigned mag;
		longint unsigned q;
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// golden resolution of one query under the given gains
	function automatic contact_t resolve_contact(input query_t q,
			input logic [GAIN_W-1:0] spd, input logic [GAIN_W-1:0] mom);
		contact_t c;
		longint cx, cy, vx, vy, r, nx, ny, dx, dy;
		longint unsigned ax, ay, d2, ds;
		cx = longint'($signed(q.cx));
		cy = longint'($signed(q.cy));
		vx = longint'($signed(q.vx));
		vy = longint'($signed(q.vy));
		r  = longint'(q.r);
		nx = cx;
		ny = cy;
		if (nx > longint'($signed(q.left)) + longint'(q.w))
			nx = longint'($signed(q.left)) + longint'(q.w);
		if (nx < longint'($signed(q.left))) nx = longint'($signed(q.left));
		if (ny > longint'($signed(q.top)) + longint'(q.h))
			ny = longint'($signed(q.top)) + longint'(q.h);
		if (ny < longint'($signed(q.top))) ny = longint'($signed(q.top));
		dx = cx - nx;
		dy = cy - ny;
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		c.x = q.cx;
		c.y = q.cy;
		c.vx = q.vx;
		c.vy = q.vy;
		c.hit = 1'b0;
		// no contact: center inside the box, or too far on either axis
		if ((ax == 0 && ay == 0) || ax >= r || ay >= r) return c;
		d2 = ax * ax + ay * ay;
		if (d2 >= r * r) return c;
		ds = int_sqrt(d2 << 16);
		c.x = POS_W'(sat24(nx + round_div(dx * r * 256, ds)));
		c.y = POS_W'(sat24(ny + round_div(dy * r * 256, ds)));
		// dominant axis is bounced; a tie bounces y
		if (ax > ay) vx = -vx;
		else vy = -vy;
		c.vx = POS_W'(sat24(apply_gain(vx, spd) +
			apply_gain(longint'($signed(q.bvx)), mom)));
		c.vy = POS_W'(sat24(apply_gain(vy, spd) +
			apply_gain(longint'($signed(q.bvy)), mom)));
		c.hit = 1'b1;
		return c;
	endfunction

	class contact_scoreboard;
		contact_t pending[$];
		logic [GAIN_W-1:0] speedup = SPEEDUP_RESET;
		logic [GAIN_W-1:0] momentum = MOMENTUM_RESET;

		function void note_query(input query_t q);
			pending.push_back(resolve_contact(q, speedup, momentum));
		endfunction

		task check_contact(input contact_t got);
			contact_t want;
			if (pending.size() == 0) begin
				report_mismatch("unexpected result", 32'(got.x), 32'd0);
				return;
			end
			want = pending.pop_front();
			if (got.x !== want.x) report_mismatch("new_x", 32'(got.x), 32'(want.x));
			if (got.y !== want.y) report_mismatch("new_y", 32'(got.y), 32'(want.y));
			if (got.vx !== want.vx) report_mismatch("new_vx", 32'(got.vx), 32'(want.vx));
			if (got.vy !== want.vy) report_mismatch("new_vy", 32'(got.vy), 32'(want.vy));
			if (got.hit !== want.hit) report_mismatch("hit", 32'(got.hit), 32'(want.hit));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic out_valid;
	logic out_stall = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_SPEEDUP;
	logic [GAIN_W-1:0] cfg_data = '0;
	query_t cur = '{default: '0};
	logic [POS_W-1:0] new_x, new_y, new_vx, new_vy;
	logic hit;

	contact_scoreboard sb = new();
	int send_idle = 0;
	int recv_idle = 0;
	int quiet_cycles = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	circle_box_collision_response u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.circle_x(cur.cx), .circle_y(cur.cy), .circle_vx(cur.vx), .circle_vy(cur.vy),
		.circle_radius(cur.r), .box_left(cur.left), .box_top(cur.top),
		.box_width(cur.w), .box_height(cur.h), .box_vx(cur.bvx), .box_vy(cur.bvy),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.new_x(new_x), .new_y(new_y), .new_vx(new_vx), .new_vy(new_vy), .hit(hit)
	);

	// receiver: sample the output transaction at the rising edge
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_contact('{new_x, new_y, new_vx, new_vy, hit});
	end

	// receiver stall changes at the falling edge
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	// watchdog on cycles with no transaction at all
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WD_LIMIT) begin
			$display("watchdog expired");
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic write_gain(input cfg_reg_t idx, input logic [GAIN_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SPEEDUP) sb.speedup = val;
		else sb.momentum = val;
	endtask

	// send one query, holding it until the block takes it
	task automatic send_query(input query_t q);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		cur <= q;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_query(q);
		@(negedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (PIPE_LAT + 5) @(negedge clk);
	endtask

	function automatic logic [POS_W-1:0] rand_pos;
		return POS_W'($urandom);
	endfunction

	// a query that mostly lands near a box edge or corner so contacts happen
	function automatic query_t near_query;
		query_t q;
		int unsigned mode;
		longint base_x, base_y, px, py;
		mode = $urandom_range(9);
		q.vx = rand_pos();
		q.vy = rand_pos();
		q.bvx = rand_pos();
		q.bvy = rand_pos();
		if (mode == 0) begin
			q.cx = rand_pos();
			q.cy = rand_pos();
			q.r = RAD_W'($urandom);
			q.left = rand_pos();
			q.top = rand_pos();
			q.w = SIZE_W'($urandom);
			q.h = SIZE_W'($urandom);
			return q;
		end
		q.r = (mode == 1) ? RAD_W'($urandom) : RAD_W'($urandom_range(4000, 1));
		q.w = (mode == 2) ? SIZE_W'($urandom) : SIZE_W'($urandom_range(20000));
		q.h = (mode == 3) ? SIZE_W'($urandom) : SIZE_W'($urandom_range(20000));
		base_x = longint'($urandom_range(16000000)) - 8000000;
		base_y = longint'($urandom_range(16000000)) - 8000000;
		q.left = POS_W'(base_x);
		q.top = POS_W'(base_y);
		// pick a point on or off one side, within about a radius
		px = longint'($signed(q.left)) + (($urandom_range(1)) ? longint'(q.w) : 0);
		py = longint'($signed(q.top)) + (($urandom_range(1)) ? longint'(q.h) : 0);
		px += longint'($urandom_range(2 * q.r + 2)) - q.r - 1;
		py += longint'($urandom_range(2 * q.r + 2)) - q.r - 1;
		if (mode == 4) py = longint'($signed(q.top)) + $urandom_range(q.h);
		if (mode == 5) px = longint'($signed(q.left)) + $urandom_range(q.w);
		q.cx = POS_W'(px);
		q.cy = POS_W'(py);
		return q;
	endfunction

	task automatic directed_queries;
		query_t q;
		q = '{default: '0};
		q.r = 16'd1000;
		q.w = 23'd2000;
		q.h = 23'd2000;
		q.vx = 24'd300;
		q.vy = -24'sd500;
		q.bvx = 24'd100;
		q.bvy = -24'sd100;
		// center inside the box
		q.cx = 24'd500; q.cy = 24'd500; send_query(q);
		// left side contact, x dominant
		q.cx = -24'sd300; q.cy = 24'd1000; send_query(q);
		// above the top edge, y dominant
		q.cx = 24'd1000; q.cy = -24'sd999; send_query(q);
		// equal offsets on a corner
		q.cx = 24'd2400; q.cy = 24'd2400; send_query(q);
		// exactly one radius away: no contact
		q.cx = 24'd3000; q.cy = 24'd1000; send_query(q);
		// on the edge itself
		q.cx = 24'd2000; q.cy = 24'd1000; send_query(q);
		// zero radius
		q.r = 16'd0; q.cx = 24'd2001; send_query(q);
		// largest radius, extreme velocities to force saturation
		q.r = 16'hffff;
		q.cx = 24'h7fffff; q.cy = 24'd1000;
		q.left = 24'h7f0000; q.w = 23'd0; q.h = 23'h7fffff; q.top = 24'h800000;
		q.vx = 24'h800000; q.vy = 24'h7fffff; q.bvx = 24'h7fffff; q.bvy = 24'h800000;
		send_query(q);
		q.cx = 24'h800000; q.left = 24'h800100; q.vx = 24'h7fffff;
		send_query(q);
		q.cy = 24'h800000; q.top = 24'h800001; q.h = 23'h7fffff; q.left = 24'h800000;
		q.w = 23'h7fffff; q.cx = 24'd0; send_query(q);
		q.cy = 24'h7fffff; q.top = 24'h7fff00; q.h = 23'd0; send_query(q);
	endtask

	task automatic random_phase(input int n, input int s_idle, input int r_idle);
		send_idle = s_idle;
		recv_idle = r_idle;
		repeat (n) send_query(near_query());
		drain();
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// default gains first
		directed_queries();
		drain();

		// gain extremes
		write_gain(REG_SPEEDUP, 16'hffff);
		write_gain(REG_MOMENTUM, 16'hffff);
		directed_queries();
		drain();
		write_gain(REG_SPEEDUP, 16'd0);
		write_gain(REG_MOMENTUM, 16'd0);
		directed_queries();
		drain();

		write_gain(REG_SPEEDUP, 16'($urandom));
		write_gain(REG_MOMENTUM, 16'($urandom));
		random_phase(N_RANDOM / 3, 28, 50);
		write_gain(REG_SPEEDUP, SPEEDUP_RESET);
		write_gain(REG_MOMENTUM, MOMENTUM_RESET);
		random_phase(N_RANDOM / 3, 50, 28);
		write_gain(REG_SPEEDUP, 16'h8000);
		write_gain(REG_MOMENTUM, 16'($urandom));
		random_phase(N_RANDOM / 3, 0, 0);

		if (errors == 0 && sb.pending.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
